// File: hdl/hsv_to_rgb_pixel_core_macros.svh
`ifndef HSV_TO_RGB_PIXEL_CORE_MACROS_SVH
`define HSV_TO_RGB_PIXEL_CORE_MACROS_SVH

// Clocked on clock, off while reset is high.
`define HSV2RGB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked on clock, also checked while reset is high.
`define HSV2RGB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

   localparam int COMPONENT_BITS_DEF = 8;

   // register stages from input to output, output register included
   localparam int PIPE_DEPTH = 6;

   typedef logic [2:0] sext_type;

   localparam sext_type SEXT_R_TO_Y = 3'd0;
   localparam sext_type SEXT_Y_TO_G = 3'd1;
   localparam sext_type SEXT_G_TO_C = 3'd2;
   localparam sext_type SEXT_C_TO_B = 3'd3;
   localparam sext_type SEXT_B_TO_M = 3'd4;
   localparam sext_type SEXT_M_TO_R = 3'd5;
   localparam sext_type SEXT_WRAP   = 3'd6;

endpackage

// File: hdl/hsv_to_rgb_pixel_core.sv
// HSV to RGB pixel converter, six-stage pipeline.
// Path: an accepted req word is registered in stages 0 to 4 and then in the output register, which drives rsp_valid.
// Throughput: one word per clock while the output is not stalled; a stall holds full stages, and empty ones still fill.
// The multiply stages and the divide-by-M folds set the stage count.
// Reset (synchronous, active high) clears all stage valid bits; data registers keep junk.
module hsv_to_rgb_pixel_core #(
   parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [COMPONENT_BITS-1:0] req_hue,
   input  logic [COMPONENT_BITS-1:0] req_saturation,
   input  logic [COMPONENT_BITS-1:0] req_brightness,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COMPONENT_BITS-1:0] rsp_red,
   output logic [COMPONENT_BITS-1:0] rsp_green,
   output logic [COMPONENT_BITS-1:0] rsp_blue
);
   import hsv2rgb_pkg::*;

   localparam int N = COMPONENT_BITS;
   localparam logic [N-1:0]   M  = {N{1'b1}};
   localparam logic [2*N-1:0] MM = {{(N-1){1'b1}}, 1'b0, {(N-1){1'b0}}, 1'b1};

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in, stage_en;

   // stage 0: sextant split
   sext_type     s0_sext_in;
   logic [N-1:0] s0_frac_in;
   sext_type     s0_sext_ff;
   logic [N-1:0] s0_frac_ff, s0_sat_ff, s0_val_ff;

   // stage 1: products
   logic [2*N-1:0] s1_sr_in, s1_smr_in, s1_vms_in;
   logic [2*N-1:0] s1_sr_ff, s1_smr_ff, s1_vms_ff;
   sext_type       s1_sext_ff;
   logic [N-1:0]   s1_val_ff;

   // stage 2: q and t weights, p
   logic [2*N-1:0] s2_wq_in, s2_wt_in;
   logic [N-1:0]   s2_p_in;
   logic [2*N-1:0] s2_wq_ff, s2_wt_ff;
   logic [N-1:0]   s2_p_ff, s2_val_ff;
   sext_type       s2_sext_ff;

   // stage 3: scaled by value
   logic [3*N-1:0] s3_xq_in, s3_xt_in;
   logic [3*N-1:0] s3_xq_ff, s3_xt_ff;
   logic [N-1:0]   s3_p_ff, s3_val_ff;
   sext_type       s3_sext_ff;

   // stage 4: first divide by M
   logic [2*N-1:0] s4_yq_in, s4_yt_in;
   logic [2*N-1:0] s4_yq_ff, s4_yt_ff;
   logic [N-1:0]   s4_p_ff, s4_val_ff;
   sext_type       s4_sext_ff;

   // stage 5: second divide by M, routing
   logic [N-1:0] q_val, t_val;
   logic [N-1:0] red_in, green_in, blue_in;
   logic [N-1:0] red_ff, green_ff, blue_ff;

   // a stage advances when it is empty or the next one advances
   always_comb begin
      stage_en[PIPE_DEPTH-1] = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], req_valid};
   assign req_ready = stage_en[0];
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   hsv2rgb_sextant #(.COMPONENT_BITS(N)) u_sextant (
      .hue  (req_hue),
      .sext (s0_sext_in),
      .frac (s0_frac_in)
   );

   assign s1_sr_in  = {{N{1'b0}}, s0_sat_ff} * {{N{1'b0}}, s0_frac_ff};
   assign s1_smr_in = {{N{1'b0}}, s0_sat_ff} * {{N{1'b0}}, M - s0_frac_ff};
   assign s1_vms_in = {{N{1'b0}}, s0_val_ff} * {{N{1'b0}}, M - s0_sat_ff};

   assign s2_wq_in = MM - s1_sr_ff;
   assign s2_wt_in = MM - s1_smr_ff;

   hsv2rgb_div_m #(.COMPONENT_BITS(N)) u_div_p (
      .num (s1_vms_ff),
      .quo (s2_p_in)
   );

   assign s3_xq_in = {{(2*N){1'b0}}, s2_val_ff} * {{N{1'b0}}, s2_wq_ff};
   assign s3_xt_in = {{(2*N){1'b0}}, s2_val_ff} * {{N{1'b0}}, s2_wt_ff};

   hsv2rgb_fold #(.COMPONENT_BITS(N)) u_fold_q (
      .num (s3_xq_ff),
      .quo (s4_yq_in)
   );

   hsv2rgb_fold #(.COMPONENT_BITS(N)) u_fold_t (
      .num (s3_xt_ff),
      .quo (s4_yt_in)
   );

   hsv2rgb_div_m #(.COMPONENT_BITS(N)) u_div_q (
      .num (s4_yq_ff),
      .quo (q_val)
   );

   hsv2rgb_div_m #(.COMPONENT_BITS(N)) u_div_t (
      .num (s4_yt_ff),
      .quo (t_val)
   );

   always_comb begin
      unique case (s4_sext_ff)
         SEXT_R_TO_Y: begin
            red_in = s4_val_ff; green_in = t_val;     blue_in = s4_p_ff;
         end
         SEXT_Y_TO_G: begin
            red_in = q_val;     green_in = s4_val_ff; blue_in = s4_p_ff;
         end
         SEXT_G_TO_C: begin
            red_in = s4_p_ff;   green_in = s4_val_ff; blue_in = t_val;
         end
         SEXT_C_TO_B: begin
            red_in = s4_p_ff;   green_in = q_val;     blue_in = s4_val_ff;
         end
         SEXT_B_TO_M: begin
            red_in = t_val;     green_in = s4_p_ff;   blue_in = s4_val_ff;
         end
         default: begin
            red_in = s4_val_ff; green_in = s4_p_ff;   blue_in = q_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_sext_ff <= s0_sext_in;
         s0_frac_ff <= s0_frac_in;
         s0_sat_ff  <= req_saturation;
         s0_val_ff  <= req_brightness;
      end
      if (stage_en[1]) begin
         s1_sr_ff   <= s1_sr_in;
         s1_smr_ff  <= s1_smr_in;
         s1_vms_ff  <= s1_vms_in;
         s1_sext_ff <= s0_sext_ff;
         s1_val_ff  <= s0_val_ff;
      end
      if (stage_en[2]) begin
         s2_wq_ff   <= s2_wq_in;
         s2_wt_ff   <= s2_wt_in;
         s2_p_ff    <= s2_p_in;
         s2_sext_ff <= s1_sext_ff;
         s2_val_ff  <= s1_val_ff;
      end
      if (stage_en[3]) begin
         s3_xq_ff   <= s3_xq_in;
         s3_xt_ff   <= s3_xt_in;
         s3_p_ff    <= s2_p_ff;
         s3_sext_ff <= s2_sext_ff;
         s3_val_ff  <= s2_val_ff;
      end
      if (stage_en[4]) begin
         s4_yq_ff   <= s4_yq_in;
         s4_yt_ff   <= s4_yt_in;
         s4_p_ff    <= s3_p_ff;
         s4_sext_ff <= s3_sext_ff;
         s4_val_ff  <= s3_val_ff;
      end
      if (stage_en[5]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

// File: hdl/hsv2rgb_sextant.sv
module hsv2rgb_sextant #(
   parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
   input  logic [COMPONENT_BITS-1:0] hue,
   output hsv2rgb_pkg::sext_type     sext,
   output logic [COMPONENT_BITS-1:0] frac
);
   import hsv2rgb_pkg::*;

   localparam int N = COMPONENT_BITS;
   localparam logic [N:0] M_X = {1'b0, {N{1'b1}}};

   logic [N+2:0] hue6;
   logic [2:0]   hi;
   logic [N:0]   rem;

   // 6*h = hi*2^N + lo = hi*M + (hi + lo), and hi + lo stays below 2*M
   assign hue6 = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
   assign hi   = hue6[N+2:N];
   assign rem  = {1'b0, hue6[N-1:0]} + (N+1)'(hi);

   always_comb begin
      if (rem >= M_X) begin
         sext = hi + 3'd1;
         frac = N'(rem - M_X);
      end else begin
         sext = hi;
         frac = rem[N-1:0];
      end
      // full circle wraps to the first sextant
      if (sext == SEXT_WRAP) begin
         sext = SEXT_R_TO_Y;
         frac = '0;
      end
   end

endmodule

// File: hdl/hsv2rgb_div_m.sv
module hsv2rgb_div_m #(
   parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
   input  logic [2*COMPONENT_BITS-1:0] num,
   output logic [COMPONENT_BITS-1:0]   quo
);
   localparam int N = COMPONENT_BITS;
   localparam logic [N:0] M_X  = {1'b0, {N{1'b1}}};
   localparam logic [N:0] M2_X = {{N{1'b1}}, 1'b0};

   logic [N:0] digit_sum;
   logic [1:0] corr;

   // num = hi*M + (hi + lo); num <= M*M keeps the quotient in N bits
   assign digit_sum = {1'b0, num[2*N-1:N]} + {1'b0, num[N-1:0]};

   always_comb begin
      if (digit_sum >= M2_X) begin
         corr = 2'd2;
      end else if (digit_sum >= M_X) begin
         corr = 2'd1;
      end else begin
         corr = 2'd0;
      end
   end

   assign quo = num[2*N-1:N] + N'(corr);

endmodule

// File: hdl/hsv2rgb_fold.sv
module hsv2rgb_fold #(
   parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
   input  logic [3*COMPONENT_BITS-1:0] num,
   output logic [2*COMPONENT_BITS-1:0] quo
);
   localparam int N = COMPONENT_BITS;
   localparam logic [N+1:0] M_X  = {2'b00, {N{1'b1}}};
   localparam logic [N+1:0] M2_X = {1'b0, {N{1'b1}}, 1'b0};
   localparam logic [N+1:0] M3_X = M_X + M2_X;

   logic [N-1:0]   d2, d1, d0;
   logic [N+1:0]   digit_sum;
   logic [1:0]     corr;
   logic [2*N+1:0] base;

   // 2^2N = M*(2^N+1) + 1 and 2^N = M + 1, so the digits fold into the quotient
   assign d2        = num[3*N-1:2*N];
   assign d1        = num[2*N-1:N];
   assign d0        = num[N-1:0];
   assign digit_sum = (N+2)'(d2) + (N+2)'(d1) + (N+2)'(d0);

   always_comb begin
      if (digit_sum >= M3_X) begin
         corr = 2'd3;
      end else if (digit_sum >= M2_X) begin
         corr = 2'd2;
      end else if (digit_sum >= M_X) begin
         corr = 2'd1;
      end else begin
         corr = 2'd0;
      end
   end

   assign base = {2'b00, d2, {N{1'b0}}} + (2*N+2)'(d2) + (2*N+2)'(d1) + (2*N+2)'(corr);
   assign quo  = base[2*N-1:0];

endmodule

// File: hdl/hsv2rgb_checker.sv
`include "hsv_to_rgb_pixel_core_macros.svh"

module hsv2rgb_checker #(
   parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [COMPONENT_BITS-1:0] req_hue,
   input logic [COMPONENT_BITS-1:0] req_saturation,
   input logic [COMPONENT_BITS-1:0] req_brightness,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [COMPONENT_BITS-1:0] rsp_red,
   input logic [COMPONENT_BITS-1:0] rsp_green,
   input logic [COMPONENT_BITS-1:0] rsp_blue
);
   import hsv2rgb_pkg::*;

   localparam int CW = $clog2(PIPE_DEPTH + 1);

   logic                        req_fire, rsp_fire, rsp_stall;
   logic [3*COMPONENT_BITS-1:0] rsp_word;
   logic [CW-1:0]               pending_ff, pending_in;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_red, rsp_green, rsp_blue};

   // words accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + CW'(1);
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `HSV2RGB_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_word), "rsp word not held")
   `HSV2RGB_ASSERT(a_depth_cap, pending_ff <= CW'(PIPE_DEPTH), "too many words in flight")
   `HSV2RGB_ASSERT(a_no_phantom, rsp_valid |-> pending_ff != '0, "rsp word without req word")
   `HSV2RGB_ASSERT(a_stall_origin, !req_ready |-> rsp_stall, "input stalled, output free")
   `HSV2RGB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp_valid after reset")

endmodule

bind hsv_to_rgb_pixel_core hsv2rgb_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_checker (.*);

// File: dv/hsv_to_rgb_pixel_monitor.sv
`timescale 1ns / 100ps

// Watches both channels, predicts each RGB word from the HSV word that was
// accepted, and compares in order.
module hsv_to_rgb_pixel_monitor #(
   parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [COMPONENT_BITS-1:0] req_hue,
   input  logic [COMPONENT_BITS-1:0] req_saturation,
   input  logic [COMPONENT_BITS-1:0] req_brightness,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [COMPONENT_BITS-1:0] rsp_red,
   input  logic [COMPONENT_BITS-1:0] rsp_green,
   input  logic [COMPONENT_BITS-1:0] rsp_blue,
   output int                        mismatches,
   output int                        pending,
   output int                        pixels_checked
);
   import hsv2rgb_pkg::*;

   typedef logic [COMPONENT_BITS-1:0] comp_type;
   typedef struct packed {
      comp_type red;
      comp_type green;
      comp_type blue;
   } rgb_type;

   rgb_type expected_rgb[$];
   int      fail_total = 0;
   int      done_total = 0;

   // Exact rational HSV to RGB, every component truncated toward zero.
   function automatic rgb_type hsv_to_rgb(input comp_type hue, input comp_type sat,
                                          input comp_type val);
      longint unsigned full, full_sq, h6, frac, idx, p, q, t;
      sext_type        sext;
      rgb_type         pix;
      full    = (64'd1 << COMPONENT_BITS) - 1;
      full_sq = full * full;
      if (sat == 0) begin
         pix = '{val, val, val};
      end else begin
         h6   = hue * 64'd6;
         idx  = h6 / full;
         frac = h6 % full;
         // full-circle hue lands back on red
         if (idx >= 6) begin
            idx  = 0;
            frac = 0;
         end
         sext = sext_type'(idx);
         p = (val * (full - sat)) / full;
         q = (val * (full_sq - sat * frac)) / full_sq;
         t = (val * (full_sq - sat * (full - frac))) / full_sq;
         case (sext)
            SEXT_R_TO_Y: pix = '{val, comp_type'(t), comp_type'(p)};
            SEXT_Y_TO_G: pix = '{comp_type'(q), val, comp_type'(p)};
            SEXT_G_TO_C: pix = '{comp_type'(p), val, comp_type'(t)};
            SEXT_C_TO_B: pix = '{comp_type'(p), comp_type'(q), val};
            SEXT_B_TO_M: pix = '{comp_type'(t), comp_type'(p), val};
            default:     pix = '{val, comp_type'(p), comp_type'(q)};
         endcase
      end
      return pix;
   endfunction

   function automatic int field_diff(input string name, input comp_type want,
                                     input comp_type got);
      if (got === want) return 0;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      rgb_type want;
      int      errs;
      errs = 0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rgb.size() == 0) begin
               $display("%0t: unexpected rgb word, expected none actual %0d/%0d/%0d",
                        $time, rsp_red, rsp_green, rsp_blue);
               errs = 1;
            end else begin
               want = expected_rgb.pop_front();
               errs = field_diff("red",   want.red,   rsp_red)
                    + field_diff("green", want.green, rsp_green)
                    + field_diff("blue",  want.blue,  rsp_blue);
               done_total++;
            end
         end
         if (req_valid && req_ready)
            expected_rgb.push_back(hsv_to_rgb(req_hue, req_saturation, req_brightness));
      end
      fail_total     = fail_total + errs;
      mismatches     <= fail_total;
      pending        <= expected_rgb.size();
      pixels_checked <= done_total;
   end

endmodule

// File: dv/hsv_to_rgb_pixel_core_tb.sv
`timescale 1ns / 100ps

module hsv_to_rgb_pixel_core_tb;
   import hsv2rgb_pkg::*;

   localparam int CB          = COMPONENT_BITS_DEF;
   localparam int HOLD_CYCLES = 250;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic [CB-1:0] comp_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   comp_type req_hue = '0;
   comp_type req_saturation = '0;
   comp_type req_brightness = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   comp_type rsp_red, rsp_green, rsp_blue;

   int mismatches, pending, pixels_checked;
   int send_gap_pct  = 8;
   int recv_gap_pct  = 79;
   int hold_requests = 0;
   int cycle_count   = 0;
   int pixels_sent   = 0;

   always #5 clock = ~clock;

   hsv_to_rgb_pixel_core #(.COMPONENT_BITS(CB)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   hsv_to_rgb_pixel_monitor #(.COMPONENT_BITS(CB)) u_rgb_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .mismatches     (mismatches),
      .pending        (pending),
      .pixels_checked (pixels_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: random back-pressure, plus a long hold when one is requested.
   initial begin : drain
      int stall_left;
      int holds_seen;
      stall_left = 0;
      holds_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   // Offer one word; return at the edge where it is taken.
   task automatic send_pixel(input comp_type hue, input comp_type sat, input comp_type val);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= val;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // Drop valid and hold until every pixel in flight has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Lean toward the rails so black, white, grey and hue wrap show up often.
   function automatic comp_type pick_component();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return comp_type'($urandom);
      endcase
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_pixel(pick_component(), pick_component(), pick_component());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // rails, grey, hue wrap, and hues at or across each sextant boundary
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd128, 8'd0,   8'd173);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd42,  8'd255, 8'd255);
      send_pixel(8'd43,  8'd255, 8'd255);
      send_pixel(8'd85,  8'd255, 8'd255);
      send_pixel(8'd86,  8'd255, 8'd255);
      send_pixel(8'd127, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd255, 8'd255);
      send_pixel(8'd170, 8'd255, 8'd255);
      send_pixel(8'd171, 8'd255, 8'd255);
      send_pixel(8'd212, 8'd255, 8'd255);
      send_pixel(8'd213, 8'd255, 8'd255);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd200, 8'd180);
      send_pixel(8'd1,   8'd1,   8'd255);
      send_pixel(8'd100, 8'd255, 8'd0);
      send_pixel(8'd200, 8'd128, 8'd64);
      send_pixel(8'd30,  8'd170, 8'd85);
      send_pixel(8'd85,  8'd1,   8'd254);

      send_random(380);
      wait_drained();

      send_gap_pct = 79;
      recv_gap_pct = 8;
      send_random(380);
      wait_drained();

      // stall the output for a long stretch while words keep coming
      send_gap_pct  = 0;
      recv_gap_pct  = 0;
      hold_requests = hold_requests + 1;
      send_random(370);
      wait_drained();
      repeat (PIPE_DEPTH * 4) @(negedge clock);

      $display("Sent %0d HSV pixels, %0d RGB words checked, %0d mismatches, %0d left over",
               pixels_sent, pixels_checked, mismatches, pending);
      $display("Covered sextant edges, hue wrap, grey, rails and heavy stalls on both sides");
      if (mismatches == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
